// ===== design/vsd_pkg.sv =====
// Shared types and constants for the varint64 stream decoder.
// Used by vsd_core, vsd_out_fifo, the top level and the checker.
package vsd_pkg;

    localparam longint unsigned MAX_BUFFER_BYTES = 64'd1048575;
    localparam logic [19:0] CONSUMED_CAP =
        (MAX_BUFFER_BYTES < 64'hFFFFF) ? 20'(MAX_BUFFER_BYTES) : 20'hFFFFF;

    localparam logic [15:0] LIMIT_RESET  = 16'hFFFF;
    localparam logic        KIND_VALUE   = 1'b0;
    localparam logic        KIND_SUMMARY = 1'b1;
    localparam logic [3:0]  LEN_NINE     = 4'd9;
    localparam logic [3:0]  SEVEN_BIT_BYTES = 4'd8;

    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic               kind;
        logic signed [63:0] value;
        logic [3:0]         len;
        logic [15:0]        count;
        logic [19:0]        consumed;
        logic               trunc;
        logic               last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

// ===== design/vsd_core.sv =====
// Input register, varint accumulation state and per-byte result formation.
// Depends on vsd_pkg; pushes up to two results per byte into vsd_out_fifo.
module vsd_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_buffer_end,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    input  logic           i_room,
    output vsd_pkg::t_push o_push
);
    import vsd_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_end;
    logic [63:0] r_acc;
    logic [3:0]  r_biv;
    logic [15:0] r_cnt;
    logic [19:0] r_cons;
    logic [15:0] r_limit;

    logic [63:0] n_acc;
    logic [3:0]  n_biv;
    logic [15:0] n_cnt;
    logic [19:0] n_cons;

    logic        fire;
    logic        done;
    logic [3:0]  len;
    logic [5:0]  shamt;
    logic [20:0] cons_sum;
    logic [63:0] acc_upd;

    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;
    assign shamt   = {r_biv[2:0], 3'b000} - {3'b000, r_biv[2:0]};

    always_comb begin
        n_acc    = r_acc;
        n_biv    = r_biv;
        n_cnt    = r_cnt;
        n_cons   = r_cons;
        done     = 1'b0;
        len      = '0;
        acc_upd  = r_acc;
        cons_sum = '0;
        o_push   = '0;
        if (r_cnt < r_limit) begin
            if (r_biv < SEVEN_BIT_BYTES) begin
                acc_upd = r_acc | ({57'b0, r_byte[6:0]} << shamt);
                len     = r_biv + 4'd1;
                done    = !r_byte[7];
                n_biv   = len;
            end else begin
                acc_upd = r_acc | {r_byte, 56'b0};
                len     = LEN_NINE;
                done    = 1'b1;
            end
            n_acc = acc_upd;
            if (done) begin
                cons_sum = {1'b0, r_cons} + 21'(len);
                n_cnt    = r_cnt + 16'd1;
                n_cons   = (cons_sum > {1'b0, CONSUMED_CAP}) ? CONSUMED_CAP : cons_sum[19:0];
                n_acc    = '0;
                n_biv    = '0;
                o_push.v0          = 1'b1;
                o_push.r0.kind     = KIND_VALUE;
                o_push.r0.value    = acc_upd;
                o_push.r0.len      = len;
                o_push.r0.count    = n_cnt;
                o_push.r0.consumed = n_cons;
                o_push.r0.trunc    = 1'b0;
                o_push.r0.last     = !r_end;
            end
        end
        if (r_end) begin
            if (done) begin
                o_push.v1          = 1'b1;
                o_push.r1.kind     = KIND_SUMMARY;
                o_push.r1.count    = n_cnt;
                o_push.r1.consumed = n_cons;
                o_push.r1.trunc    = (n_biv != 4'd0);
                o_push.r1.last     = 1'b1;
            end else begin
                o_push.v0          = 1'b1;
                o_push.r0.kind     = KIND_SUMMARY;
                o_push.r0.count    = n_cnt;
                o_push.r0.consumed = n_cons;
                o_push.r0.trunc    = (n_biv != 4'd0);
                o_push.r0.last     = 1'b1;
            end
            n_acc  = '0;
            n_biv  = '0;
            n_cnt  = '0;
            n_cons = '0;
        end
        if (!fire) begin
            o_push.v0 = 1'b0;
            o_push.v1 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_acc      <= '0;
            r_biv      <= '0;
            r_cnt      <= '0;
            r_cons     <= '0;
            r_limit    <= LIMIT_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_acc  <= n_acc;
                r_biv  <= n_biv;
                r_cnt  <= n_cnt;
                r_cons <= n_cons;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
            r_end  <= i_buffer_end;
        end
    end

endmodule

// ===== design/vsd_out_fifo.sv =====
// Result queue: takes up to two results per cycle, delivers one per request.
// Depends on vsd_pkg for the result and push types.
module vsd_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vsd_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output vsd_pkg::t_result o_result
);
    import vsd_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_count;
    logic [FIFO_AW-1:0]   wr_next;
    logic [FIFO_AW:0]     n_push;
    logic                 pop;

    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_room   = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_result = r_mem[r_rd];
    assign wr_next  = r_wr + {{(FIFO_AW-1){1'b0}}, 1'b1};
    assign n_push   = (FIFO_AW+1)'(i_push.v0) + (FIFO_AW+1)'(i_push.v1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + n_push[FIFO_AW-1:0];
            r_count <= r_count + n_push - (FIFO_AW+1)'(pop);
            if (pop) begin
                r_rd <= r_rd + {{(FIFO_AW-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

endmodule

// ===== design/varint64_stream_decoder_top.sv =====
// Varint64 stream decoder, top level.
// Depends on vsd_pkg, vsd_core and vsd_out_fifo.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one byte of an encoded buffer per
//   request, with i_buffer_end high on the last byte of the buffer.
//   Output channel (o_valid/i_ready) carries one result per request: either a
//   decoded value with its length, or an end-of-buffer summary with the value
//   count, bytes of complete varints and a truncation flag.
//   i_cfg_we writes i_cfg_wdata into the value limit; write it only while idle.
// Path: an accepted byte is registered in the input register and decoded from
//   there; its results are written into the result queue, which offers them.
// Throughput: one byte per cycle while the result queue has room, set by the
//   single decode stage. A byte that both ends a varint and a buffer yields
//   two results; the four-entry result queue absorbs this.
// Reset: synchronous, active low; clears the decode state and the queue and
//   sets the value limit to 65535.
// Stall: while i_ready is low, results wait in the queue; o_ready drops while
//   a byte waits in the input register and the queue cannot take two more.
module varint64_stream_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_buffer_end,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_result_kind,
    output logic signed [63:0] o_decoded_value,
    output logic [3:0]         o_value_length,
    output logic [15:0]        o_values_in_buffer,
    output logic [19:0]        o_bytes_consumed,
    output logic               o_truncated,
    output logic               o_last_of_run
);
    import vsd_pkg::*;

    t_push   push;
    t_result result;
    logic    room;

    vsd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_buffer_end (i_buffer_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_room       (room),
        .o_push       (push)
    );

    vsd_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_result_kind      = result.kind;
    assign o_decoded_value    = result.value;
    assign o_value_length     = result.len;
    assign o_values_in_buffer = result.count;
    assign o_bytes_consumed   = result.consumed;
    assign o_truncated        = result.trunc;
    assign o_last_of_run      = result.last;

endmodule

// ===== design/vsd_checker.sv =====
// Port-level checker for the varint64 stream decoder, bound to the top level.
// Depends on vsd_pkg for the result kind codes and the length bound.
module vsd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_result_kind,
    input logic signed [63:0] o_decoded_value,
    input logic [3:0]         o_value_length,
    input logic [15:0]        o_values_in_buffer,
    input logic [19:0]        o_bytes_consumed,
    input logic               o_truncated,
    input logic               o_last_of_run
);
    import vsd_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_decoded_value)
            && $stable(o_result_kind) && $stable(o_last_of_run))
        else $error("stalled result changed");

    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_SUMMARY |->
            o_value_length == 4'd0 && o_decoded_value == 64'sd0 && o_last_of_run)
        else $error("malformed summary");

    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_VALUE |->
            o_value_length != 4'd0 && o_value_length <= LEN_NINE && !o_truncated
            && o_values_in_buffer != 16'd0 && o_bytes_consumed != 20'd0)
        else $error("malformed value result");

endmodule

bind varint64_stream_decoder_top vsd_checker u_vsd_checker (.*);
